// ----- design/fnsw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fnsw_pkg
// Shared types and constants for the first-negative sliding window block.
// -----------------------------------------------------------------------------
package fnsw_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int CSR_W          = 7;
   localparam int MAX_WINDOW_DEF = 64;

   localparam logic [CSR_W-1:0] WINDOW_SIZE_RESET = 7'd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       stream_start;
      logic                       stream_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] first_negative;
      logic                       found;
      logic                       last;
   } rsp_type;

   // Per-beat controls broadcast to every cell
   typedef struct packed {
      logic                acc;
      logic                clr;
      logic                push;
      logic [SAMPLE_W-1:0] sample;
   } step_type;

   typedef struct packed {
      logic pend;
      logic clean;
   } status_type;

endpackage
`default_nettype wire

// ----- design/fnsw_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fnsw_cell
// One queue slot: a negative sample and its age, shifting toward the head.
// -----------------------------------------------------------------------------
module fnsw_cell
   import fnsw_pkg::*;
#(
   parameter int CW = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire step_type            step,
   input  wire logic                shift,
   input  wire logic [CW-1:0]       k,
   input  wire logic                up_keep,
   input  wire logic [SAMPLE_W-1:0] up_value,
   input  wire logic [CW-1:0]       up_age,
   input  wire logic                low_src_valid,
   output logic                     keep_o,
   output logic                     src_valid_o,
   output logic                     valid_o,
   output logic [SAMPLE_W-1:0]      value_o,
   output logic [CW-1:0]            age_o
);

   logic                valid_ff, valid_in;
   logic [SAMPLE_W-1:0] value_ff, value_in;
   logic [CW-1:0]       age_ff, age_in;
   logic                keep;
   logic                src_valid;
   logic [SAMPLE_W-1:0] src_value;
   logic [CW-1:0]       src_age;
   logic                take;

   // drop the entry on a stream restart or once it has aged out of the window
   assign keep = valid_ff && !step.clr && !(step.acc && (age_ff >= k));

   assign src_valid = shift ? up_keep  : keep;
   assign src_value = shift ? up_value : value_ff;
   assign src_age   = shift ? up_age   : age_ff;

   // the new sample lands just past the last occupied slot
   assign take = step.push && !src_valid && low_src_valid;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
         value_in = step.sample;
         age_in   = CW'(1);
      end else begin
         valid_in = src_valid;
         value_in = src_value;
         age_in   = step.acc ? src_age + CW'(1) : src_age;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign keep_o      = keep;
   assign src_valid_o = src_valid;
   assign valid_o     = valid_ff;
   assign value_o     = value_ff;
   assign age_o       = age_ff;

endmodule
`default_nettype wire

// ----- design/fnsw_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fnsw_ctrl
// Window size register, stream tracking, result staging and handshakes.
// -----------------------------------------------------------------------------
module fnsw_ctrl
   import fnsw_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   localparam int CW = $clog2(MAX_WINDOW + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_payload,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CSR_W-1:0]    csr_data,
   input  wire logic                head_valid,
   input  wire logic [SAMPLE_W-1:0] head_value,
   input  wire logic                any_valid,
   output step_type                 step,
   output logic [CW-1:0]            k,
   output status_type               status
);

   localparam int KW = (CW > CSR_W) ? CW : CSR_W;

   logic [CSR_W-1:0] ws_ff;
   logic [CW-1:0]    cnt_ff, cnt_in, cnt_cur;
   logic             filled_ff, filled_cur;
   logic             ended_ff;
   logic             pend_ff, pend_last_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic [KW-1:0]    ws_ext, k_full;
   logic             acc, clr, emit;
   logic             clean, out_free, move;

   assign csr_ready = 1'b1;

   // clamp the window size to 1..MAX_WINDOW
   assign ws_ext = KW'(ws_ff);
   assign k_full = (ws_ff == '0) ? KW'(1)
                 : ((ws_ext > KW'(MAX_WINDOW)) ? KW'(MAX_WINDOW) : ws_ext);
   assign k      = k_full[CW-1:0];

   // hold input while a staged result cannot leave yet
   assign clean     = head_valid || !any_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = pend_ff && clean && out_free;
   assign req_stall = pend_ff && !move;

   assign acc = req_valid && !req_stall;
   assign clr = acc && (req_payload.stream_start || ended_ff);

   assign cnt_cur    = clr ? '0 : cnt_ff;
   assign filled_cur = clr ? 1'b0 : filled_ff;
   assign cnt_in     = (cnt_cur == CW'(MAX_WINDOW)) ? cnt_cur : cnt_cur + CW'(1);
   assign emit       = acc && (filled_cur ||
                       (({1'b0, cnt_cur} + (CW+1)'(1)) >= {1'b0, k}));

   assign step.acc    = acc;
   assign step.clr    = clr;
   assign step.push   = acc && req_payload.sample[SAMPLE_W-1];
   assign step.sample = req_payload.sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= WINDOW_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         ws_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         filled_ff <= 1'b0;
         ended_ff  <= 1'b0;
      end else if (acc) begin
         cnt_ff    <= cnt_in;
         filled_ff <= emit;
         ended_ff  <= req_payload.stream_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (emit) begin
         pend_ff <= 1'b1;
      end else if (move) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pend_last_ff <= req_payload.stream_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_ff.first_negative <= head_valid ? head_value : '0;
         rsp_ff.found          <= head_valid;
         rsp_ff.last           <= pend_last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;
   assign status.pend  = pend_ff;
   assign status.clean = clean;

endmodule
`default_nettype wire

// ----- design/first_negative_sliding_window_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// first_negative_sliding_window_top
// Oldest negative sample in a sliding window, kept in a row of queue cells.
//
//   channel | ports                            | direction
//   --------+----------------------------------+---------------------------
//   req     | req_valid, req_stall, req_payload | samples in
//   rsp     | rsp_valid, rsp_stall, rsp_payload | window results out
//   csr     | csr_valid, csr_ready, csr_data    | window size write
//
// One sample per cycle while req_stall is low; each result is first staged
// as pending, then registered onto rsp. After the window size shrinks, the
// first sample may drop several entries; the row then closes the gap one
// cell per cycle with req_stall high before that result leaves.
// Reset is synchronous; queue cells need no clearing pass.
// A stalled rsp holds the result; one more sample is taken before req stalls.
// -----------------------------------------------------------------------------
module first_negative_sliding_window_top
   import fnsw_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CSR_W-1:0] csr_data
);

   localparam int CW = $clog2(MAX_WINDOW + 1);

   step_type            step;
   status_type          status;
   logic [CW-1:0]       k;
   logic                shift;
   logic                any_src;
   logic                any_valid;
   logic [MAX_WINDOW:0] keep_w;
   logic [MAX_WINDOW-1:0] src_v;
   logic [MAX_WINDOW-1:0] valid_w;
   logic [MAX_WINDOW-1:0] low_v;
   logic [SAMPLE_W-1:0] value_w [MAX_WINDOW+1];
   logic [CW-1:0]       age_w [MAX_WINDOW+1];

   // nothing shifts in past the last cell
   assign keep_w[MAX_WINDOW]  = 1'b0;
   assign value_w[MAX_WINDOW] = '0;
   assign age_w[MAX_WINDOW]   = '0;

   // advance the row whenever the head slot is empty
   assign shift     = !keep_w[0];
   assign any_src   = |src_v;
   assign any_valid = |valid_w;
   assign low_v[0]  = !any_src;

   genvar i;
   generate
      for (i = 1; i < MAX_WINDOW; i++) begin : g_low
         assign low_v[i] = src_v[i-1];
      end
      for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
         fnsw_cell #(
            .CW (CW)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .step          (step),
            .shift         (shift),
            .k             (k),
            .up_keep       (keep_w[i+1]),
            .up_value      (value_w[i+1]),
            .up_age        (age_w[i+1]),
            .low_src_valid (low_v[i]),
            .keep_o        (keep_w[i]),
            .src_valid_o   (src_v[i]),
            .valid_o       (valid_w[i]),
            .value_o       (value_w[i]),
            .age_o         (age_w[i])
         );
      end
   endgenerate

   fnsw_ctrl #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .head_valid  (valid_w[0]),
      .head_value  (value_w[0]),
      .any_valid   (any_valid),
      .step        (step),
      .k           (k),
      .status      (status)
   );

`ifndef SYNTHESIS
   a_zero_when_none : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.first_negative == '0)
      else $error("result without negative carries a nonzero value");

   a_stall_on_gap : assert property (@(posedge clock) disable iff (reset)
      status.pend && !status.clean |-> req_stall)
      else $error("sample taken while the queue head is still being compacted");

   a_head_age : assert property (@(posedge clock) disable iff (reset)
      valid_w[0] |-> age_w[0] != '0)
      else $error("queue head holds a zero age");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(status.pend))
      else $error("result appeared without a staged sample");
`endif

endmodule
`default_nettype wire
